### design/sptree_pkg.sv
// ----------------------------------------------------------------------------
// sptree_pkg
// Shared constants and state types for the shortest path tree engine.
// ----------------------------------------------------------------------------
package sptree_pkg;

    localparam int MAX_NODES   = 64;
    localparam int NODE_BITS   = $clog2(MAX_NODES);
    localparam int MAX_EDGES   = 256;
    localparam int EDGE_BITS   = $clog2(MAX_EDGES);
    localparam int WEIGHT_BITS = 16;
    localparam int DIST_BITS   = 24;

    localparam logic [DIST_BITS-1:0] INF_DIST = '1;

    typedef enum logic [1:0] {
        OP_EDGE   = 2'd0,
        OP_MEMBER = 2'd1,
        OP_RUN    = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic {
        RET_BUILD,
        RET_RELAX
    } t_ret;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_RUN_START,
        ST_ES_TEST,
        ST_ES_CHK,
        ST_HB_START,
        ST_HB_RD1,
        ST_HB_RD2,
        ST_HB_RD3,
        ST_HB_NEXT,
        ST_SU_START,
        ST_SU_N,
        ST_SU_K,
        ST_SU_LOOP,
        ST_SU_P1,
        ST_SU_P2,
        ST_SU_END,
        ST_POP_START,
        ST_POP_C,
        ST_POP_D,
        ST_POP_SCAN,
        ST_POP_MATCH,
        ST_POP_LAST,
        ST_POP_L2,
        ST_SD_K,
        ST_SD_LOOP,
        ST_SD_C1,
        ST_SD_C2,
        ST_SD_C3,
        ST_SD_C4,
        ST_SD_CMP,
        ST_SD_END,
        ST_EMIT,
        ST_RX_TEST,
        ST_RX_E,
        ST_RX_A,
        ST_RX_D,
        ST_RX_NEXT,
        ST_FINISH
    } t_state;

endpackage

### design/shortest_path_tree_engine_unit.sv
// ----------------------------------------------------------------------------
// shortest_path_tree_engine_unit
// Collects weighted undirected edges and member nodes, then builds a
// shortest path tree from a source with a binary min-heap, one tree edge
// per node taken from the heap.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                        | tuser  | tlast
//  s_axis   | in  | end_a 6, end_b 6, weight 16, member 6,    | op 2   | -
//           |     | source 6                                  |        |
//  m_axis   | out | child 6, parent 6, tree_weight 16, pad 4  | unrch  | last
//
//  an edge, member or ignored item is taken in idle, and such items can follow
//  back to back; a run holds o_s_tready low until its finish cycle has passed.
//  a run scans the stored edges for the source, then builds the heap with a
//  sift-up per entry; per popped node it searches the edges for the parent,
//  sifts the last heap entry down, relaxes the edges of the node and re-sifts
//  up each heap node whose distance fell.
//  a full output register stalls the run at its next emit.
//  reset is synchronous, active low, and clears counters and valid bits.
// ----------------------------------------------------------------------------
module shortest_path_tree_engine_unit
    import sptree_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // end_a, end_b, weight, member, source
    input  logic [1:0]  i_s_tuser,   // op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // child, parent, tree_weight, zero pad
    output logic        o_m_tuser,   // unreachable
    output logic        o_m_tlast
);

    localparam int NB = NODE_BITS;
    localparam int CB = NODE_BITS + 1;
    localparam int KB = EDGE_BITS + 1;

    // memories
    logic [NB-1:0]          r_ea_mem [MAX_EDGES];
    logic [NB-1:0]          r_eb_mem [MAX_EDGES];
    logic [WEIGHT_BITS-1:0] r_ew_mem [MAX_EDGES];
    logic [NB-1:0]          r_ml_mem [MAX_NODES];
    logic [DIST_BITS-1:0]   r_dist_mem [MAX_NODES];
    logic [NB-1:0]          r_pred_mem [MAX_NODES];
    logic [NB-1:0]          r_slot_mem [MAX_NODES];
    logic [NB-1:0]          r_hidx_mem [MAX_NODES];

    logic [NB-1:0]          r_ea_q, r_eb_q, r_ml_q, r_pred_q, r_slot_q, r_hidx_q;
    logic [WEIGHT_BITS-1:0] r_ew_q;
    logic [DIST_BITS-1:0]   r_dist_q;
    logic                   r_dv_q;
    logic [MAX_NODES-1:0]   r_dv, r_inh;

    logic [EDGE_BITS-1:0]   edge_raddr;
    logic [NB-1:0]          ml_raddr, dist_raddr, pred_raddr, slot_raddr, hidx_raddr;
    logic                   dist_we, pred_we, slot_we, hidx_we, inh_set;
    logic [NB-1:0]          dist_waddr, pred_waddr, slot_waddr, hidx_waddr, inh_addr;
    logic [DIST_BITS-1:0]   dist_wdata;
    logic [NB-1:0]          pred_wdata, slot_wdata, hidx_wdata;
    logic                   dv_clear;

    // control and datapath registers
    t_state                 r_state, n_state;
    t_ret                   r_ret, n_ret;
    logic [EDGE_BITS:0]     r_ecnt, n_ecnt;
    logic [CB-1:0]          r_mcnt, n_mcnt;
    logic [CB-1:0]          r_fill, n_fill;
    logic [NB-1:0]          r_src, n_src;
    logic [EDGE_BITS:0]     r_k, n_k;
    logic [CB-1:0]          r_i, n_i, r_j, n_j, r_sc, n_sc;
    logic [NB-1:0]          r_p, n_p, r_node, n_node, r_n1, n_n1, r_n2, n_n2;
    logic [DIST_BITS-1:0]   r_key, n_key, r_d1, n_d1, r_dc, n_dc;
    logic [NB-1:0]          r_c, n_c, r_par, n_par, r_to, n_to;
    logic [NB-1:0]          r_ea, n_ea, r_eb, n_eb;
    logic [WEIGHT_BITS-1:0] r_ew, n_ew, r_tw, n_tw;
    logic                   r_unr, n_unr, r_found, n_found, r_side, n_side;

    logic                   r_m_tvalid;
    logic [NB-1:0]          r_o_child, r_o_par;
    logic [WEIGHT_BITS-1:0] r_o_tw;
    logic                   r_o_unr, r_o_last;
    logic                   emit;

    logic                   s_acc;
    t_op                    in_op;
    logic [NB-1:0]          in_a, in_b, in_m, in_s;
    logic [WEIGHT_BITS-1:0] in_w;

    logic [DIST_BITS-1:0]   dq;
    logic [DIST_BITS:0]     nd_sum;
    logic [DIST_BITS-1:0]   nd;
    logic [CB-1:0]          jj;
    logic [CB-1:0]          sc_inc;
    logic                   can_emit;

    assign in_op = t_op'(i_s_tuser);
    assign in_a  = i_s_tdata[5:0];
    assign in_b  = i_s_tdata[11:6];
    assign in_w  = i_s_tdata[27:12];
    assign in_m  = i_s_tdata[33:28];
    assign in_s  = i_s_tdata[39:34];

    assign o_s_tready = (r_state == ST_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;

    assign dq       = r_dv_q ? r_dist_q : INF_DIST;
    assign nd_sum   = {1'b0, r_dc} + {{(DIST_BITS + 1 - WEIGHT_BITS){1'b0}}, r_ew};
    assign nd       = (nd_sum > {1'b0, INF_DIST}) ? INF_DIST : nd_sum[DIST_BITS-1:0];
    assign jj       = r_j + ((r_ml_q == r_src) ? CB'(1) : CB'(0));
    assign sc_inc   = r_sc + CB'(1);
    assign can_emit = !r_m_tvalid || i_m_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (s_acc && in_op == OP_RUN) n_state = ST_RUN_START;
            ST_RUN_START: n_state = ST_ES_TEST;
            ST_ES_TEST:   n_state = (r_k == '0) ? ST_HB_START : ST_ES_CHK;
            ST_ES_CHK:    n_state = ST_ES_TEST;
            ST_HB_START:  n_state = (r_mcnt < CB'(2)) ? ST_FINISH : ST_HB_RD1;
            ST_HB_RD1:    n_state = (r_i == r_mcnt - CB'(1)) ? ST_POP_START : ST_HB_RD2;
            ST_HB_RD2:    n_state = ST_HB_RD3;
            ST_HB_RD3:    n_state = ST_SU_START;
            ST_HB_NEXT:   n_state = ST_HB_RD1;
            ST_SU_START:  n_state = ST_SU_N;
            ST_SU_N:      n_state = ST_SU_K;
            ST_SU_K:      n_state = ST_SU_LOOP;
            ST_SU_LOOP:   n_state = (r_p == '0) ? ST_SU_END : ST_SU_P1;
            ST_SU_P1:     n_state = ST_SU_P2;
            ST_SU_P2:     n_state = (dq <= r_key) ? ST_SU_END : ST_SU_LOOP;
            ST_SU_END:    n_state = (r_ret == RET_BUILD) ? ST_HB_NEXT : ST_RX_NEXT;
            ST_POP_START: n_state = (r_fill == '0) ? ST_FINISH : ST_POP_C;
            ST_POP_C:     n_state = ST_POP_D;
            ST_POP_D:     n_state = (dq == INF_DIST) ? ST_POP_LAST : ST_POP_SCAN;
            ST_POP_SCAN:  n_state = (r_k == '0 || r_found) ? ST_POP_LAST : ST_POP_MATCH;
            ST_POP_MATCH: n_state = ST_POP_SCAN;
            ST_POP_LAST:  n_state = ST_POP_L2;
            ST_POP_L2:    n_state = ST_SD_K;
            ST_SD_K:      n_state = ST_SD_LOOP;
            ST_SD_LOOP:   n_state = (r_sc >= r_fill) ? ST_SD_END : ST_SD_C1;
            ST_SD_C1:     n_state = ST_SD_C2;
            ST_SD_C2:     n_state = (sc_inc < r_fill) ? ST_SD_C3 : ST_SD_CMP;
            ST_SD_C3:     n_state = ST_SD_C4;
            ST_SD_C4:     n_state = ST_SD_CMP;
            ST_SD_CMP:    n_state = (r_key <= r_d1) ? ST_SD_END : ST_SD_LOOP;
            ST_SD_END:    n_state = ST_EMIT;
            ST_EMIT:      if (can_emit) n_state = ST_RX_TEST;
            ST_RX_TEST:   n_state = (r_k == '0) ? ST_POP_START : ST_RX_E;
            ST_RX_E:      n_state = ST_RX_A;
            ST_RX_A: begin
                if (r_side == 1'b0) begin
                    n_state = (r_ea == r_c && r_eb != r_src) ? ST_RX_D : ST_RX_NEXT;
                end else begin
                    n_state = (r_eb == r_c && r_ea != r_src) ? ST_RX_D : ST_RX_NEXT;
                end
            end
            ST_RX_D: begin
                if (dq > nd && r_inh[r_to]) n_state = ST_SU_START;
                else                        n_state = ST_RX_NEXT;
            end
            ST_RX_NEXT:   n_state = r_side ? ST_RX_TEST : ST_RX_A;
            ST_FINISH:    n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_ret = r_ret;   n_ecnt = r_ecnt; n_mcnt = r_mcnt; n_fill = r_fill;
        n_src = r_src;   n_k = r_k;       n_i = r_i;       n_j = r_j;
        n_sc = r_sc;     n_p = r_p;       n_node = r_node; n_n1 = r_n1;
        n_n2 = r_n2;     n_key = r_key;   n_d1 = r_d1;     n_dc = r_dc;
        n_c = r_c;       n_par = r_par;   n_to = r_to;     n_ea = r_ea;
        n_eb = r_eb;     n_ew = r_ew;     n_tw = r_tw;     n_unr = r_unr;
        n_found = r_found; n_side = r_side;
        edge_raddr = r_k[EDGE_BITS-1:0] - EDGE_BITS'(1);
        ml_raddr = '0; dist_raddr = '0; pred_raddr = '0; slot_raddr = '0;
        hidx_raddr = '0;
        dist_we = 1'b0; dist_waddr = '0; dist_wdata = '0;
        pred_we = 1'b0; pred_waddr = '0; pred_wdata = '0;
        slot_we = 1'b0; slot_waddr = '0; slot_wdata = '0;
        hidx_we = 1'b0; hidx_waddr = '0; hidx_wdata = '0;
        inh_set = 1'b0; inh_addr = '0;
        dv_clear = 1'b0; emit = 1'b0;
        unique case (r_state) inside
            ST_IDLE: begin
                if (s_acc) begin
                    case (in_op)
                        OP_EDGE:   if (!r_ecnt[EDGE_BITS]) n_ecnt = r_ecnt + KB'(1);
                        OP_MEMBER: if (!r_mcnt[NB]) n_mcnt = r_mcnt + CB'(1);
                        OP_RUN:    n_src = in_s;
                        default:   ;
                    endcase
                end
            end
            ST_RUN_START: begin
                dv_clear = 1'b1;
                n_k = r_ecnt;
            end
            ST_ES_TEST: if (r_k != '0) n_k = r_k - KB'(1);
            ST_ES_CHK: begin
                if (r_ea_q == r_src || r_eb_q == r_src) begin
                    dist_we    = 1'b1;
                    dist_waddr = (r_ea_q == r_src) ? r_eb_q : r_ea_q;
                    dist_wdata = {{(DIST_BITS - WEIGHT_BITS){1'b0}}, r_ew_q};
                    pred_we    = 1'b1;
                    pred_waddr = dist_waddr;
                    pred_wdata = r_src;
                end
            end
            ST_HB_START: begin
                n_i = '0;
                n_j = '0;
            end
            ST_HB_RD1: begin
                ml_raddr = r_i[NB-1:0];
                if (r_i == r_mcnt - CB'(1)) n_fill = r_mcnt - CB'(1);
            end
            ST_HB_RD2: begin
                n_j      = jj;
                ml_raddr = jj[NB-1:0];
            end
            ST_HB_RD3: begin
                slot_we    = 1'b1;
                slot_waddr = r_i[NB-1:0];
                slot_wdata = r_j[NB] ? '0 : r_ml_q;
                inh_set    = 1'b1;
                inh_addr   = slot_wdata;
                n_j        = r_j + CB'(1);
                n_p        = r_i[NB-1:0];
                n_ret      = RET_BUILD;
            end
            ST_HB_NEXT: n_i = r_i + CB'(1);
            ST_SU_START: slot_raddr = r_p;
            ST_SU_N: begin
                n_node     = r_slot_q;
                dist_raddr = r_slot_q;
            end
            ST_SU_K: n_key = dq;
            ST_SU_LOOP: slot_raddr = (r_p - NB'(1)) >> 1;
            ST_SU_P1: begin
                n_n1       = r_slot_q;
                dist_raddr = r_slot_q;
            end
            ST_SU_P2: begin
                if (!(dq <= r_key)) begin
                    slot_we    = 1'b1;
                    slot_waddr = r_p;
                    slot_wdata = r_n1;
                    hidx_we    = 1'b1;
                    hidx_waddr = r_n1;
                    hidx_wdata = r_p;
                    n_p        = (r_p - NB'(1)) >> 1;
                end
            end
            ST_SU_END, ST_SD_END: begin
                slot_we    = 1'b1;
                slot_waddr = r_p;
                slot_wdata = r_node;
                hidx_we    = 1'b1;
                hidx_waddr = r_node;
                hidx_wdata = r_p;
            end
            ST_POP_START: slot_raddr = '0;
            ST_POP_C: begin
                n_c        = r_slot_q;
                dist_raddr = r_slot_q;
                pred_raddr = r_slot_q;
            end
            ST_POP_D: begin
                n_dc    = dq;
                n_unr   = (dq == INF_DIST);
                n_par   = (dq == INF_DIST) ? '0 : r_pred_q;
                n_tw    = '0;
                n_found = 1'b0;
                n_k     = r_ecnt;
            end
            ST_POP_SCAN: if (r_k != '0 && !r_found) n_k = r_k - KB'(1);
            ST_POP_MATCH: begin
                if ((r_ea_q == r_c && r_eb_q == r_par) ||
                    (r_eb_q == r_c && r_ea_q == r_par)) begin
                    n_tw    = r_ew_q;
                    n_found = 1'b1;
                end
            end
            ST_POP_LAST: slot_raddr = NB'(r_fill - CB'(1));
            ST_POP_L2: begin
                n_node     = r_slot_q;
                dist_raddr = r_slot_q;
                n_fill     = r_fill - CB'(1);
                n_p        = '0;
                n_sc       = CB'(1);
            end
            ST_SD_K: n_key = dq;
            ST_SD_LOOP: slot_raddr = r_sc[NB-1:0];
            ST_SD_C1: begin
                n_n1       = r_slot_q;
                dist_raddr = r_slot_q;
            end
            ST_SD_C2: begin
                n_d1       = dq;
                slot_raddr = sc_inc[NB-1:0];
            end
            ST_SD_C3: begin
                n_n2       = r_slot_q;
                dist_raddr = r_slot_q;
            end
            ST_SD_C4: begin
                if (r_d1 > dq) begin
                    n_n1 = r_n2;
                    n_d1 = dq;
                    n_sc = sc_inc;
                end
            end
            ST_SD_CMP: begin
                if (!(r_key <= r_d1)) begin
                    slot_we    = 1'b1;
                    slot_waddr = r_p;
                    slot_wdata = r_n1;
                    hidx_we    = 1'b1;
                    hidx_waddr = r_n1;
                    hidx_wdata = r_p;
                    n_p        = r_sc[NB-1:0];
                    n_sc       = {r_sc[NB-1:0], 1'b1};
                end
            end
            ST_EMIT: begin
                if (can_emit) begin
                    emit = 1'b1;
                    n_k  = r_ecnt;
                end
            end
            ST_RX_TEST: if (r_k != '0) n_k = r_k - KB'(1);
            ST_RX_E: begin
                n_ea   = r_ea_q;
                n_eb   = r_eb_q;
                n_ew   = r_ew_q;
                n_side = 1'b0;
            end
            ST_RX_A: begin
                n_to       = r_side ? r_ea : r_eb;
                dist_raddr = n_to;
                hidx_raddr = n_to;
            end
            ST_RX_D: begin
                if (dq > nd) begin
                    dist_we    = 1'b1;
                    dist_waddr = r_to;
                    dist_wdata = nd;
                    pred_we    = 1'b1;
                    pred_waddr = r_to;
                    pred_wdata = r_c;
                    n_p        = r_hidx_q;
                    n_ret      = RET_RELAX;
                end
            end
            ST_RX_NEXT: n_side = 1'b1;
            ST_FINISH: begin
                n_ecnt = '0;
                n_mcnt = '0;
                n_fill = '0;
            end
            default: ;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (s_acc && in_op == OP_EDGE && !r_ecnt[EDGE_BITS]) begin
            r_ea_mem[r_ecnt[EDGE_BITS-1:0]] <= in_a;
            r_eb_mem[r_ecnt[EDGE_BITS-1:0]] <= in_b;
            r_ew_mem[r_ecnt[EDGE_BITS-1:0]] <= in_w;
        end
        if (s_acc && in_op == OP_MEMBER && !r_mcnt[NB]) begin
            r_ml_mem[r_mcnt[NB-1:0]] <= in_m;
        end
        if (dist_we) r_dist_mem[dist_waddr] <= dist_wdata;
        if (pred_we) r_pred_mem[pred_waddr] <= pred_wdata;
        if (slot_we) r_slot_mem[slot_waddr] <= slot_wdata;
        if (hidx_we) r_hidx_mem[hidx_waddr] <= hidx_wdata;
        r_ea_q   <= r_ea_mem[edge_raddr];
        r_eb_q   <= r_eb_mem[edge_raddr];
        r_ew_q   <= r_ew_mem[edge_raddr];
        r_ml_q   <= r_ml_mem[ml_raddr];
        r_dist_q <= r_dist_mem[dist_raddr];
        r_dv_q   <= r_dv[dist_raddr];
        r_pred_q <= r_pred_mem[pred_raddr];
        r_slot_q <= r_slot_mem[slot_raddr];
        r_hidx_q <= r_hidx_mem[hidx_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ecnt     <= '0;
            r_mcnt     <= '0;
            r_fill     <= '0;
            r_dv       <= '0;
            r_inh      <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ecnt  <= n_ecnt;
            r_mcnt  <= n_mcnt;
            r_fill  <= n_fill;
            if (dv_clear) begin
                r_dv  <= '0;
                r_inh <= '0;
            end else begin
                if (dist_we) r_dv[dist_waddr] <= 1'b1;
                if (inh_set) r_inh[inh_addr] <= 1'b1;
            end
            if (emit)            r_m_tvalid <= 1'b1;
            else if (i_m_tready) r_m_tvalid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;   r_src <= n_src;   r_k <= n_k;       r_i <= n_i;
        r_j <= n_j;       r_sc <= n_sc;     r_p <= n_p;       r_node <= n_node;
        r_n1 <= n_n1;     r_n2 <= n_n2;     r_key <= n_key;   r_d1 <= n_d1;
        r_dc <= n_dc;     r_c <= n_c;       r_par <= n_par;   r_to <= n_to;
        r_ea <= n_ea;     r_eb <= n_eb;     r_ew <= n_ew;     r_tw <= n_tw;
        r_unr <= n_unr;   r_found <= n_found; r_side <= n_side;
        if (emit) begin
            r_o_child <= r_c;
            r_o_par   <= r_par;
            r_o_tw    <= r_tw;
            r_o_unr   <= r_unr;
            r_o_last  <= (r_fill == '0);
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {4'b0000, r_o_tw, r_o_par, r_o_child};
    assign o_m_tuser  = r_o_unr;
    assign o_m_tlast  = r_o_last;

endmodule
